// File: src/clfsm_pkg.sv
// -----------------------------------------------------------------------------
// clfsm_pkg
// Types, codes and constants shared by the load discovery block.
// -----------------------------------------------------------------------------
package clfsm_pkg;

   localparam int unsigned CHAN_W   = 4;
   localparam int unsigned WATT_W   = 20;
   localparam int unsigned LOAD_W   = 21;
   localparam int unsigned STAMP_W  = 32;
   localparam int unsigned CNT_W    = 5;
   localparam int unsigned MASK_W   = 16;
   localparam int unsigned LIMIT_W  = 16;
   localparam int unsigned CSR_AW   = 5;
   localparam int unsigned CSR_DW   = 32;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_POLL  = 2'd1;
   localparam logic [1:0] KIND_STOP  = 2'd2;

   localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

   localparam logic [2:0] REG_MAINS_MASK   = 3'd0;
   localparam logic [2:0] REG_JUMP_LOW     = 3'd1;
   localparam logic [2:0] REG_JUMP_HIGH    = 3'd2;
   localparam logic [2:0] REG_DROP_MARGIN  = 3'd3;
   localparam logic [2:0] REG_SCAN_TIMEOUT = 3'd4;
   localparam logic [2:0] REG_OFF_TIMEOUT  = 3'd5;

   localparam logic [MASK_W-1:0]  RST_MAINS_MASK   = 16'd0;
   localparam logic [LIMIT_W-1:0] RST_JUMP_LOW     = 16'd600;
   localparam logic [LIMIT_W-1:0] RST_JUMP_HIGH    = 16'd1200;
   localparam logic [LIMIT_W-1:0] RST_DROP_MARGIN  = 16'd500;
   localparam logic [STAMP_W-1:0] RST_SCAN_TIMEOUT = 32'd60000;
   localparam logic [STAMP_W-1:0] RST_OFF_TIMEOUT  = 32'd30000;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_SCAN = 3'd1,
      PH_WAIT = 3'd2,
      PH_CONF = 3'd3,
      PH_MISC = 3'd4,
      PH_TOUT = 3'd5
   } phase_type;

   typedef struct packed {
      logic [MASK_W-1:0]  mains_mask;
      logic [LIMIT_W-1:0] jump_low;
      logic [LIMIT_W-1:0] jump_high;
      logic [LIMIT_W-1:0] drop_margin;
      logic [STAMP_W-1:0] scan_timeout_ms;
      logic [STAMP_W-1:0] off_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic                     wr_en;
      logic                     rd_en;
      logic [CHAN_W-1:0]        addr;
      logic signed [WATT_W-1:0] wr_data;
   } ram_ctl_type;

endpackage

// File: src/clfsm_req_if.sv
// -----------------------------------------------------------------------------
// clfsm_req_if
// Reading channel: one channel reading per transaction.
// -----------------------------------------------------------------------------
interface clfsm_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         kind;
   logic [clfsm_pkg::CHAN_W-1:0]       channel;
   logic                               usable;
   logic signed [clfsm_pkg::WATT_W-1:0] watts;
   logic                               last;
   logic [clfsm_pkg::STAMP_W-1:0]      now_ms;

   modport source (output valid, kind, channel, usable, watts, last, now_ms, input ready);
   modport sink   (input valid, kind, channel, usable, watts, last, now_ms, output ready);
endinterface

// File: src/clfsm_rsp_if.sv
// -----------------------------------------------------------------------------
// clfsm_rsp_if
// Status channel: one discovery status per transaction.
// -----------------------------------------------------------------------------
interface clfsm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [2:0]                         run_state;
   logic                               candidate_valid;
   logic [clfsm_pkg::CHAN_W-1:0]       candidate;
   logic signed [clfsm_pkg::LOAD_W-1:0] load_watts;
   logic                               keep_polling;

   modport source (output valid, run_state, candidate_valid, candidate, load_watts,
                   keep_polling, input ready);
   modport sink   (input valid, run_state, candidate_valid, candidate, load_watts,
                   keep_polling, output ready);
endinterface

// File: src/circuit_load_discovery_fsm_core.sv
// -----------------------------------------------------------------------------
// circuit_load_discovery_fsm_core
// Locates the power channel carrying a switched test load.
// -----------------------------------------------------------------------------
// Takes one channel reading per clock. A reading reads its channel's baseline
// from a synchronous RAM at the edge that accepts it and is evaluated in the
// next cycle; the transaction that ends a poll, a start or a stop moves
// through the stage-1 register and then loads the status output register.
// Throughput is one reading per cycle, set by the single baseline RAM read
// and write per cycle; the input stalls only while a finished status waits
// to be taken and the reading under evaluation also produces a status.
module circuit_load_discovery_fsm_core #(
   parameter int unsigned CHANNELS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   clfsm_req_if.sink                         req_bus,
   clfsm_rsp_if.source                       rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [clfsm_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [clfsm_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [clfsm_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                              csr_pready
);
   import clfsm_pkg::*;

   localparam int unsigned ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   cfg_type                  cfg;
   ram_ctl_type              ram_ctl;
   logic signed [WATT_W-1:0] base_rd;

   clfsm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   clfsm_ram #(
      .WIDTH (WATT_W),
      .DEPTH (CHANNELS)
   ) u_base_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.wr_en),
      .wr_addr (ram_ctl.addr[ADDR_W-1:0]),
      .wr_data (ram_ctl.wr_data),
      .rd_en   (ram_ctl.rd_en),
      .rd_addr (ram_ctl.addr[ADDR_W-1:0]),
      .rd_data (base_rd)
   );

   clfsm_scan #(
      .CHANNELS (CHANNELS)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .ram_ctl (ram_ctl),
      .base_rd (base_rd)
   );

endmodule

// File: src/clfsm_ram.sv
// -----------------------------------------------------------------------------
// clfsm_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module clfsm_ram #(
   parameter int unsigned WIDTH = 20,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/clfsm_csr.sv
// -----------------------------------------------------------------------------
// clfsm_csr
// Configuration registers behind an APB-style port.
// -----------------------------------------------------------------------------
module clfsm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [clfsm_pkg::CSR_AW-1:0]      paddr,
   input  logic [clfsm_pkg::CSR_DW-1:0]      pwdata,
   output logic [clfsm_pkg::CSR_DW-1:0]      prdata,
   output logic                              pready,
   output clfsm_pkg::cfg_type                cfg
);
   import clfsm_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] idx;
   logic       wr_hit;

   assign idx    = paddr[CSR_AW-1:2];
   assign wr_hit = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_hit) begin
         case (idx)
            REG_MAINS_MASK:   cfg_in.mains_mask      = pwdata[MASK_W-1:0];
            REG_JUMP_LOW:     cfg_in.jump_low        = pwdata[LIMIT_W-1:0];
            REG_JUMP_HIGH:    cfg_in.jump_high       = pwdata[LIMIT_W-1:0];
            REG_DROP_MARGIN:  cfg_in.drop_margin     = pwdata[LIMIT_W-1:0];
            REG_SCAN_TIMEOUT: cfg_in.scan_timeout_ms = pwdata[STAMP_W-1:0];
            REG_OFF_TIMEOUT:  cfg_in.off_timeout_ms  = pwdata[STAMP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_MAINS_MASK:   prdata = CSR_DW'(cfg_ff.mains_mask);
         REG_JUMP_LOW:     prdata = CSR_DW'(cfg_ff.jump_low);
         REG_JUMP_HIGH:    prdata = CSR_DW'(cfg_ff.jump_high);
         REG_DROP_MARGIN:  prdata = CSR_DW'(cfg_ff.drop_margin);
         REG_SCAN_TIMEOUT: prdata = CSR_DW'(cfg_ff.scan_timeout_ms);
         REG_OFF_TIMEOUT:  prdata = CSR_DW'(cfg_ff.off_timeout_ms);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mains_mask      <= RST_MAINS_MASK;
         cfg_ff.jump_low        <= RST_JUMP_LOW;
         cfg_ff.jump_high       <= RST_JUMP_HIGH;
         cfg_ff.drop_margin     <= RST_DROP_MARGIN;
         cfg_ff.scan_timeout_ms <= RST_SCAN_TIMEOUT;
         cfg_ff.off_timeout_ms  <= RST_OFF_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/clfsm_scan.sv
// -----------------------------------------------------------------------------
// clfsm_scan
// Reading pipeline: baseline lookup, per-poll accumulation, phase control
// and the status output register.
// -----------------------------------------------------------------------------
module clfsm_scan #(
   parameter int unsigned CHANNELS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  clfsm_pkg::cfg_type                     cfg,
   clfsm_req_if.sink                              req,
   clfsm_rsp_if.source                            rsp,
   output clfsm_pkg::ram_ctl_type                 ram_ctl,
   input  logic signed [clfsm_pkg::WATT_W-1:0]    base_rd
);
   import clfsm_pkg::*;

   localparam int unsigned DW = WATT_W + 2;

   // stage 1: accepted reading, baseline arrives from RAM
   logic                     s1_valid_ff;
   logic [1:0]               s1_kind_ff;
   logic [CHAN_W-1:0]        s1_ch_ff;
   logic                     s1_usable_ff;
   logic signed [WATT_W-1:0] s1_watts_ff;
   logic                     s1_last_ff;
   logic [STAMP_W-1:0]       s1_now_ff;

   // block state
   phase_type                phase_ff, phase_in;
   logic [STAMP_W-1:0]       start_stamp_ff, start_stamp_in;
   logic [STAMP_W-1:0]       phase_stamp_ff, phase_stamp_in;
   logic [CHAN_W-1:0]        found_ff, found_in;
   logic signed [WATT_W-1:0] peak_ff, peak_in;
   logic signed [WATT_W-1:0] cand_base_ff, cand_base_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     mrose_ff, mrose_in;
   logic                     pick_v_ff, pick_v_in;
   logic [CHAN_W-1:0]        pick_ch_ff, pick_ch_in;
   logic signed [WATT_W-1:0] pick_w_ff, pick_w_in;
   logic signed [WATT_W-1:0] pick_base_ff, pick_base_in;
   logic                     drop_ff, drop_in;

   // output register
   logic                     rsp_valid_ff;
   logic [2:0]               rsp_state_ff;
   logic                     rsp_cv_ff;
   logic [CHAN_W-1:0]        rsp_cand_ff;
   logic signed [LOAD_W-1:0] rsp_load_ff;
   logic                     rsp_keep_ff;

   logic                     req_fire;
   logic                     req_ch_ok;
   logic                     s1_ch_ok;
   logic                     s1_go;
   logic                     emit;
   logic                     keep;
   logic                     cv;
   logic signed [WATT_W-1:0] s1_bv;
   logic signed [DW-1:0]     delta;
   logic                     in_win;
   logic [STAMP_W-1:0]       el_scan;
   logic [STAMP_W-1:0]       el_wait;

   assign req_ch_ok = ({1'b0, req.channel} < (CHAN_W + 1)'(CHANNELS));
   assign s1_ch_ok  = ({1'b0, s1_ch_ff} < (CHAN_W + 1)'(CHANNELS));

   assign emit  = s1_valid_ff && s1_kind_ff != 2'd3 &&
                  (s1_kind_ff == KIND_STOP || s1_last_ff);
   assign s1_go = s1_valid_ff && (!emit || !rsp_valid_ff || rsp.ready);

   assign req.ready = !s1_valid_ff || s1_go;
   assign req_fire  = req.valid && req.ready;

   assign ram_ctl.wr_en   = req_fire && req.kind == KIND_START && req_ch_ok;
   assign ram_ctl.rd_en   = req_fire;
   assign ram_ctl.addr    = req.channel;
   assign ram_ctl.wr_data = req.usable ? req.watts : '0;

   assign s1_bv   = s1_usable_ff ? s1_watts_ff : '0;
   assign delta   = DW'(s1_watts_ff) - DW'(base_rd);
   assign in_win  = (delta >= $signed({6'b0, cfg.jump_low})) &&
                    (delta <= $signed({6'b0, cfg.jump_high}));
   assign el_scan = s1_now_ff - start_stamp_ff;
   assign el_wait = s1_now_ff - phase_stamp_ff;

   always_comb begin
      phase_in       = phase_ff;
      start_stamp_in = start_stamp_ff;
      phase_stamp_in = phase_stamp_ff;
      found_in       = found_ff;
      peak_in        = peak_ff;
      cand_base_in   = cand_base_ff;
      cnt_in         = cnt_ff;
      mrose_in       = mrose_ff;
      pick_v_in      = pick_v_ff;
      pick_ch_in     = pick_ch_ff;
      pick_w_in      = pick_w_ff;
      pick_base_in   = pick_base_ff;
      drop_in        = drop_ff;
      keep           = 1'b0;

      case (s1_kind_ff)
         KIND_START: begin
            if (s1_ch_ok) begin
               if (s1_ch_ff == found_ff) begin
                  cand_base_in = s1_bv;
               end
               if (s1_ch_ff == pick_ch_ff) begin
                  pick_base_in = s1_bv;
               end
            end
            if (s1_last_ff) begin
               phase_in       = PH_SCAN;
               start_stamp_in = s1_now_ff;
               phase_stamp_in = s1_now_ff;
               found_in       = '0;
               peak_in        = '0;
               keep           = 1'b1;
            end
         end
         KIND_POLL: begin
            if (s1_ch_ok && phase_ff == PH_SCAN && s1_usable_ff) begin
               if (in_win) begin
                  if (cnt_ff != CNT_MAX) begin
                     cnt_in = cnt_ff + 1'b1;
                  end
                  if (cfg.mains_mask[s1_ch_ff]) begin
                     mrose_in = 1'b1;
                  end else begin
                     pick_v_in    = 1'b1;
                     pick_ch_in   = s1_ch_ff;
                     pick_w_in    = s1_watts_ff;
                     pick_base_in = base_rd;
                  end
               end
            end else if (s1_ch_ok && phase_ff == PH_WAIT && s1_ch_ff == found_ff) begin
               drop_in = DW'(s1_watts_ff) < (DW'(peak_ff) - $signed({6'b0, cfg.drop_margin}));
            end
            if (s1_last_ff) begin
               case (phase_ff)
                  PH_SCAN: begin
                     if (el_scan > cfg.scan_timeout_ms) begin
                        phase_in = PH_TOUT;
                     end else if (cnt_in != '0 && pick_v_in) begin
                        found_in       = pick_ch_in;
                        peak_in        = pick_w_in;
                        cand_base_in   = pick_base_in;
                        phase_in       = PH_WAIT;
                        phase_stamp_in = s1_now_ff;
                        keep           = 1'b1;
                     end else if (cnt_in != '0 && mrose_in) begin
                        phase_in = PH_MISC;
                     end else begin
                        keep = 1'b1;
                     end
                  end
                  PH_WAIT: begin
                     if (el_wait > cfg.off_timeout_ms) begin
                        phase_in = PH_TOUT;
                     end else if (drop_in) begin
                        phase_in = PH_CONF;
                     end else begin
                        keep = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         KIND_STOP: begin
            phase_in = PH_IDLE;
         end
         default: ;
      endcase

      if (emit) begin
         cnt_in     = '0;
         mrose_in   = 1'b0;
         pick_v_in  = 1'b0;
         pick_ch_in = '0;
         pick_w_in  = '0;
         drop_in    = 1'b0;
      end
   end

   assign cv = (phase_in == PH_WAIT) || (phase_in == PH_CONF);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
      if (req_fire) begin
         s1_kind_ff   <= req.kind;
         s1_ch_ff     <= req.channel;
         s1_usable_ff <= req.usable;
         s1_watts_ff  <= req.watts;
         s1_last_ff   <= req.last;
         s1_now_ff    <= req.now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         start_stamp_ff <= '0;
         phase_stamp_ff <= '0;
         found_ff       <= '0;
         peak_ff        <= '0;
         cand_base_ff   <= '0;
         cnt_ff         <= '0;
         mrose_ff       <= 1'b0;
         pick_v_ff      <= 1'b0;
         pick_ch_ff     <= '0;
         pick_w_ff      <= '0;
         pick_base_ff   <= '0;
         drop_ff        <= 1'b0;
      end else if (s1_go) begin
         phase_ff       <= phase_in;
         start_stamp_ff <= start_stamp_in;
         phase_stamp_ff <= phase_stamp_in;
         found_ff       <= found_in;
         peak_ff        <= peak_in;
         cand_base_ff   <= cand_base_in;
         cnt_ff         <= cnt_in;
         mrose_ff       <= mrose_in;
         pick_v_ff      <= pick_v_in;
         pick_ch_ff     <= pick_ch_in;
         pick_w_ff      <= pick_w_in;
         pick_base_ff   <= pick_base_in;
         drop_ff        <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_go && emit) begin
         rsp_state_ff <= 3'(phase_in);
         rsp_cv_ff    <= cv;
         rsp_cand_ff  <= cv ? found_in : '0;
         rsp_load_ff  <= cv ? (LOAD_W'(peak_in) - LOAD_W'(cand_base_in)) : '0;
         rsp_keep_ff  <= keep;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.run_state       = rsp_state_ff;
   assign rsp.candidate_valid = rsp_cv_ff;
   assign rsp.candidate       = rsp_cand_ff;
   assign rsp.load_watts      = rsp_load_ff;
   assign rsp.keep_polling    = rsp_keep_ff;

endmodule

// File: bench/clfsm_checker.sv
// -----------------------------------------------------------------------------
// clfsm_checker
// Watches the reading, status and register ports of the load discovery block,
// keeps its own copy of the discovery state and register settings, works out
// the status due for each accepted reading that ends a start, a poll or a stop
// and compares each status transaction with the oldest one outstanding.
// Register reads are checked against the settings last written.
// -----------------------------------------------------------------------------
module clfsm_checker (
   input  logic                         clock,
   input  logic                         reset,
   clfsm_req_if                         req_bus,
   clfsm_rsp_if                         rsp_bus,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic                         csr_pready,
   input  logic [clfsm_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [clfsm_pkg::CSR_DW-1:0] csr_pwdata,
   input  logic [clfsm_pkg::CSR_DW-1:0] csr_prdata,
   output int                           fail_count,
   output int                           pending
);
   import clfsm_pkg::*;

   localparam int unsigned NUM_CHANNELS = 1 << CHAN_W;

   typedef struct packed {
      logic [2:0]               run_state;
      logic                     cand_valid;
      logic [CHAN_W-1:0]        cand;
      logic signed [LOAD_W-1:0] load_watts;
      logic                     keep_polling;
   } status_type;

   cfg_type                  cfg;
   phase_type                run_phase;
   logic signed [WATT_W-1:0] baseline [NUM_CHANNELS];
   logic [STAMP_W-1:0]       scan_start;
   logic [STAMP_W-1:0]       wait_start;
   logic [CHAN_W-1:0]        found_chan;
   logic signed [WATT_W-1:0] peak;
   logic [CNT_W-1:0]         rise_count;
   logic                     mains_rose;
   logic                     pick_valid;
   logic [CHAN_W-1:0]        pick_chan;
   logic signed [WATT_W-1:0] pick_watts;
   logic                     drop_seen;

   status_type               status_q [$];
   status_type               got;
   status_type               exp;
   logic [CSR_DW-1:0]        reg_exp;

   function automatic void clear_poll();
      rise_count = '0;
      mains_rose = 1'b0;
      pick_valid = 1'b0;
      pick_chan  = '0;
      pick_watts = '0;
      drop_seen  = 1'b0;
   endfunction

   function automatic status_type form_status(logic keep);
      status_type s;
      s = '0;
      s.run_state  = run_phase;
      s.cand_valid = (run_phase == PH_WAIT) || (run_phase == PH_CONF);
      if (s.cand_valid) begin
         s.cand       = found_chan;
         s.load_watts = LOAD_W'(int'(peak) - int'(baseline[found_chan]));
      end
      s.keep_polling = keep;
      return s;
   endfunction

   function automatic void take_reading();
      logic [1:0]               kind;
      logic [CHAN_W-1:0]        ch;
      logic                     usable;
      logic signed [WATT_W-1:0] w;
      logic                     last;
      logic [STAMP_W-1:0]       now;
      logic                     keep;
      int                       rise;
      kind   = req_bus.kind;
      ch     = req_bus.channel;
      usable = req_bus.usable;
      w      = req_bus.watts;
      last   = req_bus.last;
      now    = req_bus.now_ms;
      keep   = 1'b0;
      case (kind)
         KIND_STOP: begin
            run_phase = PH_IDLE;
            clear_poll();
            status_q.push_back(form_status(1'b0));
         end
         KIND_START: begin
            baseline[ch] = usable ? w : '0;
            if (last) begin
               run_phase  = PH_SCAN;
               scan_start = now;
               wait_start = now;
               found_chan = '0;
               peak       = '0;
               clear_poll();
               status_q.push_back(form_status(1'b1));
            end
         end
         KIND_POLL: begin
            if (run_phase == PH_SCAN && usable) begin
               rise = int'(w) - int'(baseline[ch]);
               if (rise >= int'(cfg.jump_low) && rise <= int'(cfg.jump_high)) begin
                  if (rise_count != CNT_MAX) rise_count++;
                  if (cfg.mains_mask[ch]) begin
                     mains_rose = 1'b1;
                  end else begin
                     pick_valid = 1'b1;
                     pick_chan  = ch;
                     pick_watts = w;
                  end
               end
            end else if (run_phase == PH_WAIT && ch == found_chan) begin
               drop_seen = int'(w) < int'(peak) - int'(cfg.drop_margin);
            end
            if (last) begin
               // timeouts are judged before the poll's own readings
               case (run_phase)
                  PH_SCAN: begin
                     if ((now - scan_start) > cfg.scan_timeout_ms) begin
                        run_phase = PH_TOUT;
                     end else if (rise_count != '0 && pick_valid) begin
                        found_chan = pick_chan;
                        peak       = pick_watts;
                        run_phase  = PH_WAIT;
                        wait_start = now;
                        keep       = 1'b1;
                     end else if (rise_count != '0 && mains_rose) begin
                        run_phase = PH_MISC;
                     end else begin
                        keep = 1'b1;
                     end
                  end
                  PH_WAIT: begin
                     if ((now - wait_start) > cfg.off_timeout_ms) run_phase = PH_TOUT;
                     else if (drop_seen) run_phase = PH_CONF;
                     else keep = 1'b1;
                  end
                  default: ;
               endcase
               clear_poll();
               status_q.push_back(form_status(keep));
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg = '{RST_MAINS_MASK, RST_JUMP_LOW, RST_JUMP_HIGH, RST_DROP_MARGIN,
                 RST_SCAN_TIMEOUT, RST_OFF_TIMEOUT};
         run_phase = PH_IDLE;
         foreach (baseline[i]) baseline[i] = '0;
         scan_start = '0;
         wait_start = '0;
         found_chan = '0;
         peak       = '0;
         clear_poll();
         status_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.run_state    = rsp_bus.run_state;
            got.cand_valid   = rsp_bus.candidate_valid;
            got.cand         = rsp_bus.candidate;
            got.load_watts   = rsp_bus.load_watts;
            got.keep_polling = rsp_bus.keep_polling;
            if (status_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected status: state %0d cv %0b cand %0d load %0d keep %0b",
                           got.run_state, got.cand_valid, got.cand, got.load_watts,
                           got.keep_polling);
            end else begin
               exp = status_q.pop_front();
               if (got !== exp) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"status mismatch: exp state %0d cv %0b cand %0d load %0d ",
                               "keep %0b, got state %0d cv %0b cand %0d load %0d keep %0b"},
                              exp.run_state, exp.cand_valid, exp.cand, exp.load_watts,
                              exp.keep_polling, got.run_state, got.cand_valid, got.cand,
                              got.load_watts, got.keep_polling);
               end
            end
         end
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[CSR_AW-1:2])
                  REG_MAINS_MASK:   cfg.mains_mask      = csr_pwdata[MASK_W-1:0];
                  REG_JUMP_LOW:     cfg.jump_low        = csr_pwdata[LIMIT_W-1:0];
                  REG_JUMP_HIGH:    cfg.jump_high       = csr_pwdata[LIMIT_W-1:0];
                  REG_DROP_MARGIN:  cfg.drop_margin     = csr_pwdata[LIMIT_W-1:0];
                  REG_SCAN_TIMEOUT: cfg.scan_timeout_ms = csr_pwdata[STAMP_W-1:0];
                  REG_OFF_TIMEOUT:  cfg.off_timeout_ms  = csr_pwdata[STAMP_W-1:0];
                  default: ;
               endcase
            end else begin
               case (csr_paddr[CSR_AW-1:2])
                  REG_MAINS_MASK:   reg_exp = CSR_DW'(cfg.mains_mask);
                  REG_JUMP_LOW:     reg_exp = CSR_DW'(cfg.jump_low);
                  REG_JUMP_HIGH:    reg_exp = CSR_DW'(cfg.jump_high);
                  REG_DROP_MARGIN:  reg_exp = CSR_DW'(cfg.drop_margin);
                  REG_SCAN_TIMEOUT: reg_exp = CSR_DW'(cfg.scan_timeout_ms);
                  default:          reg_exp = CSR_DW'(cfg.off_timeout_ms);
               endcase
               if (csr_prdata !== reg_exp) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("register read mismatch at %0d: exp %0h got %0h",
                              csr_paddr, reg_exp, csr_prdata);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) take_reading();
      end
      pending = status_q.size();
   end

endmodule

// File: bench/tb_circuit_load_discovery_fsm_core.sv
// -----------------------------------------------------------------------------
// tb_circuit_load_discovery_fsm_core
// Drives channel readings and register settings into the load discovery block.
// A short directed run covers field extremes and the corner cases of scanning
// and waiting; random discovery sessions (start, scan and wait polls, stops and
// noise) follow under several register settings, with random stalls on both
// sides and a long status hold-off. The checker beside the block does the
// comparing; this top gives the verdict.
// -----------------------------------------------------------------------------
module tb_circuit_load_discovery_fsm_core;
   import clfsm_pkg::*;

   localparam int         NUM_CHANNELS = 1 << CHAN_W;
   localparam int         LONG_HOLD    = 150;
   localparam int         CYCLE_LIMIT  = 500000;
   localparam int         WATT_MAX     = 2 ** (WATT_W - 1) - 1;
   localparam int         WATT_MIN     = -(2 ** (WATT_W - 1));
   localparam logic [1:0] KIND_SPARE   = 2'd3;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int                fail_count;
   int                pending;
   int                cycles     = 0;
   int                items_sent = 0;
   int                hold_asks  = 0;
   int                hold_seen  = 0;
   bit                gaps_on    = 1'b0;
   cfg_type           cfg_now;
   int                base_seen [NUM_CHANNELS];
   logic [STAMP_W-1:0] now_ms    = '0;

   clfsm_req_if req_bus ();
   clfsm_rsp_if rsp_bus ();

   circuit_load_discovery_fsm_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   clfsm_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // status receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic logic signed [WATT_W-1:0] fit_watts(int v);
      if (v > WATT_MAX) return WATT_W'(WATT_MAX);
      if (v < WATT_MIN) return WATT_W'(WATT_MIN);
      return WATT_W'(v);
   endfunction

   function automatic int any_watts();
      return int'($signed(WATT_W'($urandom())));
   endfunction

   function automatic void step_clock();
      case ($urandom_range(0, 19))
         0:       now_ms = $urandom();
         1, 2:    ;
         default: now_ms += $urandom_range(1, 8000);
      endcase
   endfunction

   function automatic cfg_type cfg_of(logic [MASK_W-1:0] mask, logic [LIMIT_W-1:0] low,
                                      logic [LIMIT_W-1:0] high, logic [LIMIT_W-1:0] drop,
                                      logic [STAMP_W-1:0] scan, logic [STAMP_W-1:0] off);
      cfg_type c;
      c.mains_mask      = mask;
      c.jump_low        = low;
      c.jump_high       = high;
      c.drop_margin     = drop;
      c.scan_timeout_ms = scan;
      c.off_timeout_ms  = off;
      return c;
   endfunction

   function automatic cfg_type random_config();
      int low;
      low = $urandom_range(0, 1500);
      return cfg_of($urandom(), low, low + $urandom_range(0, 1500), $urandom_range(0, 2000),
                    $urandom_range(5000, 80000), $urandom_range(3000, 40000));
   endfunction

   // leaves valid high on return; callers that stop sending lower it
   task automatic send_reading(logic [1:0] kind, logic [CHAN_W-1:0] ch, logic usable,
                               int w, logic last, logic [STAMP_W-1:0] stamp);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.kind    <= kind;
      req_bus.channel <= ch;
      req_bus.usable  <= usable;
      req_bus.watts   <= fit_watts(w);
      req_bus.last    <= last;
      req_bus.now_ms  <= stamp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      if (kind != KIND_SPARE) items_sent++;
      if (kind == KIND_START) base_seen[ch] = usable ? int'(fit_watts(w)) : 0;
   endtask

   task automatic send_noise();
      send_reading($urandom_range(0, 3), $urandom_range(0, NUM_CHANNELS - 1),
                   $urandom_range(0, 1), any_watts(), $urandom_range(0, 1), $urandom());
   endtask

   task automatic send_start(bit full);
      int n;
      int ch;
      int w;
      n = full ? NUM_CHANNELS : $urandom_range(1, NUM_CHANNELS);
      step_clock();
      for (int i = 0; i < n; i++) begin
         ch = full ? i : $urandom_range(0, NUM_CHANNELS - 1);
         w  = ($urandom_range(0, 15) == 0) ? any_watts()
                                           : int'($urandom_range(0, 40000)) - 20000;
         send_reading(KIND_START, ch, $urandom_range(0, 7) != 0, w, i == n - 1,
                      (i == n - 1) ? now_ms : $urandom());
      end
   endtask

   // serves as scan poll or wait poll: rises into the window, near-baseline
   // readings, window edges and wild values
   task automatic send_poll();
      int n;
      int ch;
      int w;
      int pick;
      bit hot;
      step_clock();
      n   = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
      hot = $urandom_range(0, 1);
      for (int i = 0; i < n; i++) begin
         ch   = $urandom_range(0, NUM_CHANNELS - 1);
         pick = $urandom_range(0, 9);
         if (hot && pick < 4)
            w = base_seen[ch] + int'($urandom_range(cfg_now.jump_low, cfg_now.jump_high));
         else if (pick == 4)
            w = base_seen[ch] + int'(cfg_now.jump_low) - 1;
         else if (pick == 5)
            w = base_seen[ch] + int'(cfg_now.jump_high) + 1;
         else if (pick == 6)
            w = any_watts();
         else
            w = base_seen[ch] + int'($urandom_range(0, 400)) - 200;
         if ($urandom_range(0, 29) == 0) send_noise();
         send_reading(KIND_POLL, ch, $urandom_range(0, 9) != 0, w, i == n - 1,
                      (i == n - 1) ? now_ms : $urandom());
      end
   endtask

   task automatic run_session();
      send_start($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 10)) begin
         send_poll();
         if ($urandom_range(0, 14) == 0) send_noise();
      end
      if ($urandom_range(0, 2) == 0)
         send_reading(KIND_STOP, $urandom_range(0, NUM_CHANNELS - 1), $urandom_range(0, 1),
                      any_watts(), $urandom_range(0, 1), $urandom());
   endtask

   task automatic run_until(int goal);
      while (items_sent < goal) run_session();
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      wait (pending == 0);
      @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_access(logic write, logic [2:0] idx, logic [CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_config(cfg_type c);
      cfg_now = c;
      csr_access(1'b1, REG_MAINS_MASK,   CSR_DW'(c.mains_mask));
      csr_access(1'b1, REG_JUMP_LOW,     CSR_DW'(c.jump_low));
      csr_access(1'b1, REG_JUMP_HIGH,    CSR_DW'(c.jump_high));
      csr_access(1'b1, REG_DROP_MARGIN,  CSR_DW'(c.drop_margin));
      csr_access(1'b1, REG_SCAN_TIMEOUT, CSR_DW'(c.scan_timeout_ms));
      csr_access(1'b1, REG_OFF_TIMEOUT,  CSR_DW'(c.off_timeout_ms));
      for (int i = REG_MAINS_MASK; i <= REG_OFF_TIMEOUT; i++) csr_access(1'b0, 3'(i), '0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.kind    = KIND_START;
      req_bus.channel = '0;
      req_bus.usable  = 1'b0;
      req_bus.watts   = '0;
      req_bus.last    = 1'b0;
      req_bus.now_ms  = '0;
      foreach (base_seen[i]) base_seen[i] = 0;
      cfg_now = cfg_of(RST_MAINS_MASK, RST_JUMP_LOW, RST_JUMP_HIGH, RST_DROP_MARGIN,
                       RST_SCAN_TIMEOUT, RST_OFF_TIMEOUT);
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: stop and poll end while idle, spare kind
      send_reading(KIND_STOP, 0, 1'b0, 0, 1'b1, '0);
      send_reading(KIND_POLL, 0, 1'b1, 0, 1'b1, '0);
      send_reading(KIND_SPARE, 7, 1'b1, 1234, 1'b1, '0);
      // full start near the top of the stamp range, extremes, one unusable channel
      for (int i = 0; i < NUM_CHANNELS; i++)
         send_reading(KIND_START, i, i != 2,
                      (i == 0) ? WATT_MAX : (i == 1) ? WATT_MIN : 100 * i,
                      i == NUM_CHANNELS - 1, 32'hFFFF_FF00);
      // rises exactly at both window edges, a huge rise; stamp wraps
      send_reading(KIND_POLL, 3, 1'b1, 300 + 600, 1'b0, $urandom());
      send_reading(KIND_POLL, 4, 1'b1, 400 + 1200, 1'b0, $urandom());
      send_reading(KIND_POLL, 1, 1'b1, WATT_MAX, 1'b0, $urandom());
      send_reading(KIND_POLL, 6, 1'b1, 600 + 599, 1'b1, 32'h0000_0100);
      // candidate read twice: later reading exactly at the margin wins
      send_reading(KIND_POLL, 4, 1'b1, 1600 - 501, 1'b0, $urandom());
      send_reading(KIND_POLL, 4, 1'b1, 1600 - 500, 1'b1, 32'h0000_0200);
      // unusable candidate reading still confirms the drop
      send_reading(KIND_POLL, 4, 1'b0, 1600 - 501, 1'b1, 32'h0000_0300);
      send_reading(KIND_STOP, 15, 1'b1, WATT_MIN, 1'b0, 32'hFFFF_FFFF);
      now_ms = 32'h0000_0300;

      gaps_on = 1'b1;
      run_until(120);

      drain();
      load_config(random_config());
      hold_asks++;
      run_session();
      drain();
      run_until(260);

      drain();
      gaps_on = 1'b0;
      load_config(cfg_of('1, '0, '1, '1, '0, '1));
      run_until(340);

      drain();
      gaps_on = 1'b1;
      load_config(cfg_of('0, '1, '1, '0, '1, '0));
      run_until(420);

      drain();
      load_config(cfg_of(16'h00FF, 16'd1000, 16'd10, 16'd300, 32'd40000, 32'd20000));
      run_until(480);

      drain();
      load_config(random_config());
      hold_asks++;
      run_until(640);

      drain();
      gaps_on = 1'b0;
      load_config(random_config());
      run_until(750);

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
